// File: sv/fnpll_pkg.sv
// Shared types and constants for the fractional-N PLL register calculator.
// No dependencies; the front end, arithmetic unit, emitter and top level import this package.
package fnpll_pkg;

  // Field widths
  localparam int FREQ_W     = 23;
  localparam int REF_W      = 18;
  localparam int STEP_W     = 10;
  localparam int PWR_W      = 2;
  localparam int WORD_W     = 32;
  localparam int IDX_W      = 3;
  localparam int CODE_W     = 3;
  localparam int MOD_W      = 12;
  localparam int INT_W      = 10;
  localparam int FRAC_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = REF_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWR  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [REF_W-1:0]  REF_RESET  = REF_W'(25000);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);
  localparam logic [PWR_W-1:0]  PWR_RESET  = 2'd3;
  localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(25000 / 10);

  // Operating limits (kHz)
  localparam logic [FREQ_W-1:0] FREQ_MIN_KHZ = FREQ_W'(34375);
  localparam logic [FREQ_W-1:0] FREQ_MAX_KHZ = FREQ_W'(4400000);
  localparam logic [FREQ_W-1:0] VCO_MIN_KHZ  = FREQ_W'(2200000);
  localparam logic [REF_W-1:0]  REF_MIN_KHZ  = REF_W'(10000);
  localparam logic [REF_W-1:0]  REF_MAX_KHZ  = REF_W'(250000);
  localparam logic [STEP_W-1:0] STEP_MIN_KHZ = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_MAX_KHZ = STEP_W'(1000);
  localparam logic [MOD_W-1:0]  MOD_MAX      = MOD_W'(4095);
  localparam logic [MOD_W-1:0]  MOD_MIN      = MOD_W'(10000 / 1000);
  localparam int                CODE_MAX     = 6;

  // Modulus divider (one quotient bit per cycle over the reference width)
  localparam int MOD_CNT_W = $clog2(REF_W + 1);

  // Shared radix-16 divider in the arithmetic unit
  localparam int DIV_Q_W     = 12;
  localparam int DIV_RADIX   = 4;
  localparam int DIV_CYCLES  = DIV_Q_W / DIV_RADIX;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);
  localparam int PREM_W      = REF_W + 2;
  localparam int PROD_W      = REF_W + MOD_W;
  localparam int NUM_W       = PROD_W + 1;

  // Register numbers, emitted from R5 down to R0
  localparam logic [IDX_W-1:0] REG_R5 = 3'd5;
  localparam logic [IDX_W-1:0] REG_R4 = 3'd4;
  localparam logic [IDX_W-1:0] REG_R3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_R2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_R1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_R0 = 3'd0;

  // Fixed register words
  localparam logic [WORD_W-1:0] WORD_R5      = 32'h0058_0005;
  localparam logic [WORD_W-1:0] WORD_R4_BASE = 32'h00BC_802C & ~(32'h7 << 20) & ~(32'h3 << 3);
  localparam logic [WORD_W-1:0] WORD_R3      = 32'h0000_04B3;
  localparam logic [WORD_W-1:0] WORD_R2      = (32'h0000_4E42 | (32'h1 << 28) | (32'h1 << 27))
                                               & ~(32'h1 << 26);
  localparam logic [WORD_W-1:0] WORD_R1_BASE = 32'h0000_0001 + (32'h1 << 27);

  // Live configuration seen by the back end
  typedef struct packed {
    logic [REF_W-1:0] ref_khz;
    logic [MOD_W-1:0] modulus;
    logic [PWR_W-1:0] power;
  } cfg_t;

  // Classified request between front and back
  typedef struct packed {
    logic [FREQ_W-1:0] vco;
    logic [CODE_W-1:0] code;
  } job_t;

  // Finished arithmetic for one request
  typedef struct packed {
    logic [INT_W-1:0]  int_val;
    logic [FRAC_W-1:0] frac;
    logic [MOD_W-1:0]  modulus;
    logic [CODE_W-1:0] code;
    logic [PWR_W-1:0]  power;
  } res_t;

endpackage

// File: sv/fnpll_fifo.sv
// Small register FIFO that decouples the request front end from the arithmetic unit.
// Generic width and depth; no package dependency.
module fnpll_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/fnpll_front.sv
// Front end: configuration registers, modulus divider, request clamping and
// output-divider selection. Depends on fnpll_pkg.
module fnpll_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full_o,
  input  logic [fnpll_pkg::FREQ_W-1:0]    freq_khz_i,
  input  logic                            cfg_we_i,
  input  logic [fnpll_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fnpll_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            job_valid_o,
  output fnpll_pkg::job_t                 job_o,
  input  logic                            job_full_i,
  output fnpll_pkg::cfg_t                 cfg_o
);
  import fnpll_pkg::*;

  logic [REF_W-1:0]     ref_q, ref_c;
  logic [STEP_W-1:0]    step_q, step_c;
  logic [PWR_W-1:0]     pwr_q;
  logic [MOD_W-1:0]     mod_q;
  logic                 mod_load_q, mod_busy;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [REF_W-1:0]     mnum_q, mnum_d;
  logic [STEP_W-1:0]    mrem_q, mrem_d;
  logic [STEP_W:0]      mtrial;
  logic [FREQ_W-1:0]    f_c;
  logic [CODE_W-1:0]    code;

  // Clamped configuration
  always_comb begin
    if (ref_q < REF_MIN_KHZ)      ref_c = REF_MIN_KHZ;
    else if (ref_q > REF_MAX_KHZ) ref_c = REF_MAX_KHZ;
    else                          ref_c = ref_q;
    if (step_q < STEP_MIN_KHZ)      step_c = STEP_MIN_KHZ;
    else if (step_q > STEP_MAX_KHZ) step_c = STEP_MAX_KHZ;
    else                            step_c = step_q;
  end

  // One restoring step of ref / step
  always_comb begin
    mtrial = {mrem_q, mnum_q[REF_W-1]};
    mnum_d = {mnum_q[REF_W-2:0], 1'b0};
    if (mtrial >= {1'b0, step_c}) begin
      mtrial    = mtrial - {1'b0, step_c};
      mnum_d[0] = 1'b1;
    end
    mrem_d = mtrial[STEP_W-1:0];
  end

  assign mod_busy = mod_load_q | (mod_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q      <= REF_RESET;
      step_q     <= STEP_RESET;
      pwr_q      <= PWR_RESET;
      mod_q      <= MOD_RESET;
      mod_load_q <= 1'b0;
      mod_cnt_q  <= '0;
      mnum_q     <= '0;
      mrem_q     <= '0;
    end else begin
      // A write to the reference or step restarts the modulus calculation
      mod_load_q <= cfg_we_i && (cfg_index_i == CFG_REF || cfg_index_i == CFG_STEP);
      if (mod_load_q) begin
        mnum_q     <= ref_c;
        mrem_q     <= '0;
        mod_cnt_q  <= MOD_CNT_W'(REF_W);
      end else if (mod_cnt_q != '0) begin
        mnum_q    <= mnum_d;
        mrem_q    <= mrem_d;
        mod_cnt_q <= mod_cnt_q - 1'b1;
        if (mod_cnt_q == MOD_CNT_W'(1)) begin
          mod_q <= (mnum_d > REF_W'(MOD_MAX)) ? MOD_MAX : mnum_d[MOD_W-1:0];
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_REF:  ref_q  <= cfg_data_i;
          CFG_STEP: step_q <= cfg_data_i[STEP_W-1:0];
          CFG_PWR:  pwr_q  <= cfg_data_i[PWR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Request clamp and divider code: largest code whose threshold f stays under
  always_comb begin
    if (freq_khz_i < FREQ_MIN_KHZ)      f_c = FREQ_MIN_KHZ;
    else if (freq_khz_i > FREQ_MAX_KHZ) f_c = FREQ_MAX_KHZ;
    else                                f_c = freq_khz_i;
    code = '0;
    for (int k = 1; k <= CODE_MAX; k++) begin
      if (f_c < (VCO_MIN_KHZ >> (k - 1))) code = CODE_W'(k);
    end
  end

  assign full_o      = job_full_i | mod_busy;
  assign job_valid_o = push & ~full_o;
  assign job_o.vco   = f_c << code;
  assign job_o.code  = code;

  assign cfg_o.ref_khz = ref_c;
  assign cfg_o.modulus = mod_q;
  assign cfg_o.power   = pwr_q;

  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_index_i == CFG_REF || cfg_index_i == CFG_STEP)) |=> full_o)
    else $error("requests not blocked after a reference or step write");

  a_mod_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mod_busy |-> (mod_q >= MOD_MIN))
    else $error("modulus below its floor");

endmodule

// File: sv/fnpll_calc.sv
// Arithmetic unit: INT/remainder division, rounding multiply and FRAC division
// on one shared radix-16 divider. Depends on fnpll_pkg.
module fnpll_calc (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  fnpll_pkg::job_t job_i,
  output logic            pop_o,
  input  fnpll_pkg::cfg_t cfg_i,
  output logic            res_valid_o,
  output fnpll_pkg::res_t res_o,
  input  logic            res_ready_i
);
  import fnpll_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV1, S_MUL, S_DIV2} state_e;

  state_e               state_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [PREM_W-1:0]    prem_q, step_prem, dvs;
  logic [DIV_Q_W-1:0]   lo_q, step_lo;
  logic [CODE_W-1:0]    code_q;
  logic [INT_W-1:0]     int_q;
  logic                 res_valid_q;
  res_t                 res_q;
  logic [PROD_W-1:0]    prod;
  logic [NUM_W-1:0]     num;
  logic                 last_step, adv, res_load;

  // Divisor is ref for the INT division, 2*ref for the rounded FRAC division
  assign dvs = (state_q == S_DIV2) ? {1'b0, cfg_i.ref_khz, 1'b0} : {2'b0, cfg_i.ref_khz};

  // Four restoring steps per cycle; the FRAC division holds its last step while the previous result is untaken
  always_comb begin : div_step
    logic [PREM_W-1:0] t;
    step_prem = prem_q;
    step_lo   = lo_q;
    for (int i = 0; i < DIV_RADIX; i++) begin
      t       = {step_prem[PREM_W-2:0], step_lo[DIV_Q_W-1]};
      step_lo = {step_lo[DIV_Q_W-2:0], 1'b0};
      if (t >= dvs) begin
        t          = t - dvs;
        step_lo[0] = 1'b1;
      end
      step_prem = t;
    end
  end

  assign prod = PROD_W'(prem_q[REF_W-1:0]) * PROD_W'(cfg_i.modulus);
  assign num  = {prod, 1'b0} + NUM_W'(cfg_i.ref_khz);

  assign last_step = (cnt_q == DIV_CNT_W'(1));
  assign adv       = !(last_step && res_valid_q && !res_ready_i);
  assign res_load  = (state_q == S_DIV2) && adv && last_step;
  assign pop_o     = (state_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prem_q      <= '0;
      lo_q        <= '0;
      code_q      <= '0;
      int_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_load)         res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            prem_q  <= PREM_W'(job_i.vco >> DIV_Q_W);
            lo_q    <= job_i.vco[DIV_Q_W-1:0];
            code_q  <= job_i.code;
            cnt_q   <= DIV_CNT_W'(DIV_CYCLES);
            state_q <= S_DIV1;
          end
        end
        S_DIV1: begin
          prem_q <= step_prem;
          lo_q   <= step_lo;
          cnt_q  <= cnt_q - 1'b1;
          if (last_step) state_q <= S_MUL;
        end
        S_MUL: begin
          // remainder * MOD, doubled, plus ref for round-half-up
          int_q   <= lo_q[INT_W-1:0];
          prem_q  <= PREM_W'(num >> DIV_Q_W);
          lo_q    <= num[DIV_Q_W-1:0];
          cnt_q   <= DIV_CNT_W'(DIV_CYCLES);
          state_q <= S_DIV2;
        end
        S_DIV2: begin
          if (adv) begin
            prem_q <= step_prem;
            lo_q   <= step_lo;
            cnt_q  <= cnt_q - 1'b1;
            if (last_step) begin
              res_q.int_val <= int_q;
              res_q.frac    <= step_lo;
              res_q.modulus <= cfg_i.modulus;
              res_q.code    <= code_q;
              res_q.power   <= cfg_i.power;
              state_q       <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.frac <= res_q.modulus))
    else $error("FRAC above modulus");

endmodule

// File: sv/fnpll_emit.sv
// Back end: holds one finished result and emits register words R5 down to R0.
// Depends on fnpll_pkg.
module fnpll_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        res_valid_i,
  input  fnpll_pkg::res_t             res_i,
  output logic                        res_ready_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [fnpll_pkg::WORD_W-1:0] reg_word_o,
  output logic [fnpll_pkg::IDX_W-1:0]  reg_index_o,
  output logic                        last_o
);
  import fnpll_pkg::*;

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  res_t             res_q;

  assign empty       = ~busy_q;
  assign last_o      = (idx_q == REG_R0);
  assign reg_index_o = idx_q;
  assign res_ready_o = ~busy_q | (pop & last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= REG_R5;
      res_q  <= '0;
    end else if (res_valid_i && res_ready_o) begin
      busy_q <= 1'b1;
      idx_q  <= REG_R5;
      res_q  <= res_i;
    end else if (pop && busy_q) begin
      if (last_o) busy_q <= 1'b0;
      else        idx_q  <= idx_q - 1'b1;
    end
  end

  always_comb begin
    unique case (idx_q)
      REG_R5:  reg_word_o = WORD_R5;
      REG_R4:  reg_word_o = WORD_R4_BASE | (WORD_W'(res_q.code) << 20)
                            | (WORD_W'(res_q.power) << 3);
      REG_R3:  reg_word_o = WORD_R3;
      REG_R2:  reg_word_o = WORD_R2;
      REG_R1:  reg_word_o = WORD_R1_BASE + (WORD_W'(res_q.modulus) << 3);
      REG_R0:  reg_word_o = (WORD_W'(res_q.int_val) << 15) + (WORD_W'(res_q.frac) << 3);
      default: reg_word_o = '0;
    endcase
  end

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && busy_q && last_o && !res_valid_i) |=> empty)
    else $error("emitter still busy after last word");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= REG_R5))
    else $error("register number out of range");

endmodule

// File: sv/frac_n_pll_register_calc_core.sv
// Top level of the fractional-N PLL register calculator: front end, request
// FIFO, arithmetic unit and word emitter. Depends on fnpll_pkg and all fnpll_* modules.
//
//  channel   | ports                                  | transfer
//  ----------+----------------------------------------+----------------------------
//  request   | push, full, freq_khz_i                 | push && !full
//  result    | empty, pop, reg_word_o, reg_index_o,   | pop && !empty, six per
//            | last_o                                 | request, R5 first, last on R0
//  config    | cfg_we_i, cfg_index_i, cfg_data_i      | every edge with cfg_we_i
//
// A request is classified (clamp, divider code, VCO) in the cycle it is taken and
// queued. The arithmetic unit takes one request at a time through a load, the
// radix-16 INT division, a multiply and the FRAC division. The emitter delivers one
// word per cycle while pop is held. A write to the reference or step register
// recomputes MOD in a bit-serial divider; full stays high after that write until
// the new MOD is in place. Reset is asynchronous, active low, and restores
// 25000 kHz reference, 10 kHz step and power code 3.
// Either side may stall: the FIFO and the result register keep both ends independent.
module frac_n_pll_register_calc_core #(
  parameter int JOB_DEPTH = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request
  input  logic                             push,
  output logic                             full,
  input  logic [fnpll_pkg::FREQ_W-1:0]     freq_khz_i,
  // result
  output logic                             empty,
  input  logic                             pop,
  output logic [fnpll_pkg::WORD_W-1:0]     reg_word_o,
  output logic [fnpll_pkg::IDX_W-1:0]      reg_index_o,
  output logic                             last_o,
  // config
  input  logic                             cfg_we_i,
  input  logic [fnpll_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fnpll_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fnpll_pkg::*;

  // front -> FIFO
  logic job_push, job_full;
  job_t job_in;
  // FIFO -> arithmetic unit
  logic job_pop, job_empty;
  job_t job_out;
  // live configuration
  cfg_t cfg;
  // arithmetic unit -> emitter
  logic res_valid, res_ready;
  res_t res;

  fnpll_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full_o      (full),
    .freq_khz_i  (freq_khz_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full),
    .cfg_o       (cfg)
  );

  // Short request queue between classification and arithmetic
  fnpll_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  fnpll_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (job_empty),
    .job_i       (job_out),
    .pop_o       (job_pop),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Emitter takes a new result on the same edge its last word leaves
  fnpll_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .reg_word_o  (reg_word_o),
    .reg_index_o (reg_index_o),
    .last_o      (last_o)
  );

endmodule
